/* design/wpl_pkg.sv */
// wpl_pkg: types, constants and codes shared by the wildcard pattern locator
// depends on nothing; imported by every module of the block
`default_nettype none

package wpl_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LINE_MAX    = 128;
    localparam int ROW_LIMIT   = 1024;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 7;

    // derived widths
    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W  = $clog2(LINE_MAX + 1);

    // short queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] WILDCARD = 8'h3F;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_EOL  = 2'd2,
        OP_EOT  = 2'd3
    } wpl_op_e;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  pattern_index;
        logic [CHAR_W-1:0] char_value;
    } wpl_in_t;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic              found_any;
    } wpl_out_t;

    // classified command as it sits in the queue
    typedef struct packed {
        wpl_op_e           op;
        logic              idx_ok;
        logic [PIDX_W-1:0] idx;
        logic [CHAR_W-1:0] ch;
    } wpl_cmd_t;

endpackage

`default_nettype wire

/* design/wpl_front.sv */
// wpl_front: accepts input transfers, classifies them and queues the commands
// depends on wpl_pkg
`default_nettype none

module wpl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wpl_pkg::wpl_in_t   s_data,
    output logic               deq_valid,
    output wpl_pkg::wpl_cmd_t  deq_cmd,
    input  logic               deq_ready
);
    import wpl_pkg::*;

    wpl_cmd_t          cmd_in;
    wpl_cmd_t          fifo_mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    always_comb begin
        unique case (s_data.operation)
            OP_LOAD: cmd_in.op = OP_LOAD;
            OP_TEXT: cmd_in.op = OP_TEXT;
            OP_EOL:  cmd_in.op = OP_EOL;
            default: cmd_in.op = OP_EOT;
        endcase
        // an index past the store is dropped by the back end
        cmd_in.idx_ok = (32'(s_data.pattern_index) < PATTERN_MAX);
        cmd_in.idx    = s_data.pattern_index[PIDX_W-1:0];
        cmd_in.ch     = s_data.char_value;
    end

    assign s_ready   = (count_reg != QCNT_W'(Q_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign push      = s_valid && s_ready;
    assign pop       = deq_valid && deq_ready;
    assign deq_cmd   = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= Q_DEPTH)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

/* design/wpl_back.sv */
// wpl_back: pattern store, line window, counters and the result register
// depends on wpl_pkg; takes commands from wpl_front
`default_nettype none

module wpl_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               deq_valid,
    input  wpl_pkg::wpl_cmd_t  deq_cmd,
    output logic               deq_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wpl_pkg::wpl_out_t  m_data
);
    import wpl_pkg::*;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (32'(len) > PATTERN_MAX) begin
            r = LEN_W'(PATTERN_MAX);
        end
        return r;
    endfunction

    logic [CHAR_W-1:0] pattern_reg [PATTERN_MAX];
    logic [CHAR_W-1:0] pattern_next [PATTERN_MAX];
    logic [CHAR_W-1:0] recent_reg [PATTERN_MAX];
    logic [CHAR_W-1:0] recent_next [PATTERN_MAX];
    // pattern right-aligned to the window, unused slots filled with wildcards
    logic [PATTERN_MAX-1:0][CHAR_W-1:0]   aligned_reg, aligned_next;
    logic [2*PATTERN_MAX-1:0][CHAR_W-1:0] ext_pat, ext_shift;

    logic [LEN_W-1:0] len_reg, len_next, len_eff_next, len_cur;
    logic [CNT_W-1:0] chars_reg, chars_next, chars_inc, col_full;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;
    wpl_out_t         m_data_reg, m_data_next;

    logic             can_go, exec, window_hit;
    logic [PATTERN_MAX-1:0] slot_ok;

    assign can_go    = !m_valid_reg || m_ready;
    assign exec      = deq_valid && can_go;
    assign deq_ready = can_go;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign len_next     = cfg_wr_en ? cfg_wr_data : len_reg;
    assign len_eff_next = clamp_len(len_next);
    assign len_cur      = clamp_len(len_reg);

    // pattern store update and realignment for the next cycle's compare
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pattern_next[k] = pattern_reg[k];
        end
        if (exec && deq_cmd.op == OP_LOAD && deq_cmd.idx_ok) begin
            pattern_next[deq_cmd.idx] = deq_cmd.ch;
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ext_pat[i]               = WILDCARD;
            ext_pat[PATTERN_MAX + i] = pattern_next[i];
        end
        ext_shift    = ext_pat >> {len_eff_next, 3'b000};
        aligned_next = ext_shift[PATTERN_MAX-1:0];
    end

    // compare the window as it will stand after the incoming byte
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j == PATTERN_MAX - 1) begin
                slot_ok[j] = (aligned_reg[j] == WILDCARD) || (aligned_reg[j] == deq_cmd.ch);
            end else begin
                slot_ok[j] = (aligned_reg[j] == WILDCARD) || (aligned_reg[j] == recent_reg[j+1]);
            end
        end
        window_hit = &slot_ok;
    end

    assign chars_inc = chars_reg + 1'b1;
    assign col_full  = chars_inc - CNT_W'(len_cur);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_next[k] = recent_reg[k];
        end
        chars_next   = chars_reg;
        row_next     = row_reg;
        found_next   = found_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        if (exec) begin
            unique case (deq_cmd.op)
                OP_LOAD: begin
                end
                OP_TEXT: begin
                    if (32'(chars_reg) < LINE_MAX) begin
                        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                            recent_next[k] = recent_reg[k+1];
                        end
                        recent_next[PATTERN_MAX-1] = deq_cmd.ch;
                        chars_next = chars_inc;
                        if (chars_inc >= CNT_W'(len_cur) && window_hit) begin
                            found_next            = 1'b1;
                            m_valid_next          = 1'b1;
                            m_data_next.kind      = KIND_REPORT;
                            m_data_next.row       = row_reg;
                            m_data_next.column    = col_full[COL_W-1:0];
                            m_data_next.found_any = 1'b1;
                        end
                    end
                end
                OP_EOL: begin
                    for (int k = 0; k < PATTERN_MAX; k++) begin
                        recent_next[k] = '0;
                    end
                    chars_next = '0;
                    if (row_reg != ROW_W'(ROW_LIMIT - 1)) begin
                        row_next = row_reg + 1'b1;
                    end
                end
                OP_EOT: begin
                    m_valid_next          = 1'b1;
                    m_data_next.kind      = KIND_SUMMARY;
                    m_data_next.row       = '0;
                    m_data_next.column    = '0;
                    m_data_next.found_any = found_reg;
                    for (int k = 0; k < PATTERN_MAX; k++) begin
                        recent_next[k] = '0;
                    end
                    chars_next = '0;
                    row_next   = '0;
                    found_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                recent_reg[k] <= '0;
            end
            len_reg     <= LEN_W'(1);
            chars_reg   <= '0;
            row_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                recent_reg[k] <= recent_next[k];
            end
            len_reg     <= len_next;
            chars_reg   <= chars_next;
            row_reg     <= row_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pattern_reg[k] <= pattern_next[k];
        end
        aligned_reg <= aligned_next;
        m_data_reg  <= m_data_next;
    end

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(chars_reg) <= LINE_MAX)
        else $error("line character count past line limit");

    a_report_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_REPORT) |-> found_reg)
        else $error("report shown without found flag set");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && deq_cmd.op == OP_EOT) |=>
            (row_reg == '0 && chars_reg == '0 && !found_reg && m_valid_reg))
        else $error("end of text did not clear counters or show summary");

    a_stall_no_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !exec)
        else $error("command executed while result is stalled");

endmodule

`default_nettype wire

/* design/wildcard_pattern_locator.sv */
// wildcard_pattern_locator: top level, joins the front queue and the back end
// depends on wpl_pkg, wpl_front, wpl_back
//
// Finds every occurrence of a pattern ('?' matches any byte) within lines of text.
// Load pattern bytes by index, set pattern_length through cfg_wr_en/cfg_wr_data
// while the block is idle, then stream text bytes, end-of-line and end-of-text
// items. A text byte is compared against all pattern positions at once, using a
// registered copy of the pattern realigned to the window in advance, so a new
// item is taken every cycle while the output register is empty or being read.
// An item is written into a two-entry queue between the front and the back end,
// then executed from its head; the result sits in an output register, so each
// side can stall on its own. An occurrence is reported with row and start column;
// end of text reports whether anything was found and restarts row counting.
`default_nettype none

module wildcard_pattern_locator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  wpl_pkg::wpl_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wpl_pkg::wpl_out_t  m_data
);
    import wpl_pkg::*;

    logic     deq_valid;
    logic     deq_ready;
    wpl_cmd_t deq_cmd;

    wpl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .deq_valid (deq_valid),
        .deq_cmd   (deq_cmd),
        .deq_ready (deq_ready)
    );

    wpl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .deq_valid   (deq_valid),
        .deq_cmd     (deq_cmd),
        .deq_ready   (deq_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire
